[hw/rtl/tcc_pkg.sv]
// Shared types and constants for the Type-C CC attach/detach detector.
// Holds the stream payload layouts, register indexes and reset values.
// No dependencies.
package tcc_pkg;

    // Register indexes on the configuration channel
    localparam logic [1:0] REG_ATTACH_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_DETACH_DEBOUNCE   = 2'd1;
    localparam logic [1:0] REG_CHECK_INTERVAL_MS = 2'd2;

    // Register reset values
    localparam logic [7:0]  ATTACH_DEBOUNCE_RST   = 8'd3;
    localparam logic [7:0]  DETACH_DEBOUNCE_RST   = 8'd3;
    localparam logic [15:0] CHECK_INTERVAL_MS_RST = 16'd100;

    // Interval timer and debounce count ceilings
    localparam logic [15:0] TIMER_MAX = 16'hFFFF;
    localparam logic [7:0]  COUNT_MAX = 8'hFF;

    // CC line codes
    localparam logic [1:0] LINE_NONE = 2'd0;
    localparam logic [1:0] LINE_CC1  = 2'd1;
    localparam logic [1:0] LINE_CC2  = 2'd2;

    // Comparator threshold codes
    localparam logic LEVEL_LOW = 1'b0;
    localparam logic LEVEL_MID = 1'b1;

    // Bit positions inside a line's flag set
    localparam int FLAG_LOW  = 0;
    localparam int FLAG_MID  = 1;
    localparam int FLAG_HIGH = 2;

    // Probe sequencer phases
    localparam logic [2:0] PH_CC1_LOW  = 3'd0;
    localparam logic [2:0] PH_CC1_MID  = 3'd1;
    localparam logic [2:0] PH_CC1_PIN  = 3'd2;
    localparam logic [2:0] PH_CC2_MID  = 3'd3;
    localparam logic [2:0] PH_CC2_PIN  = 3'd4;

    // Input transfer layout, last field in the lowest bits
    typedef struct packed {
        logic [1:0] pad;
        logic       fault_active;
        logic       link_ready;
        logic       rx_pending;
        logic       tx_idle;
        logic       pin_high;
        logic       cmp_out;
        logic [7:0] delta_ms;
    } tick_t;

    // Result transfer layout, last field in the lowest bits
    typedef struct packed {
        logic [2:0] pad;
        logic       vsafe_request;
        logic       reselect_event;
        logic       detach_event;
        logic       attach_event;
        logic [1:0] active_line;
        logic       is_connected;
        logic [1:0] orientation;
        logic       measure_done;
        logic       probe_level;
        logic [1:0] probe_line;
    } result_t;

    // Line terminated by a source pull-up (between 0.66 V and 2.2 V)
    function automatic logic looks_rp(input logic [2:0] f);
        return f[FLAG_MID] && !f[FLAG_HIGH];
    endfunction

    // Line open, Ra-like or driven high
    function automatic logic looks_other(input logic [2:0] f);
        return (f[FLAG_LOW] && !f[FLAG_MID]) || f[FLAG_HIGH];
    endfunction

    // Orientation from both flag sets; both lines Rp-like yields none
    function automatic logic [1:0] derive(input logic [2:0] a, input logic [2:0] b);
        logic [1:0] r;
        r = LINE_NONE;
        if (looks_rp(a) && looks_other(b)) r = LINE_CC1;
        if (looks_rp(b)) begin
            if (r != LINE_NONE) r = LINE_NONE;
            else if (looks_other(a)) r = LINE_CC2;
        end
        return r;
    endfunction

endpackage

[hw/rtl/typec_cc_attach_detect_debounce.sv]
// Type-C sink CC attach/detach detector with debounce, top level.
// Depends on tcc_pkg for payload layouts, codes and helper functions.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  s_axis   | in        | s_tvalid/s_tready  | s_tdata[15:0]  one poll tick
//  m_axis   | out       | m_tvalid/m_tready  | m_tdata[15:0]  one result per tick
//  cfg      | in        | cfg_valid/cfg_ready| cfg_index[1:0], cfg_data[15:0]
//
// Each tick passes through an input register, then one pass of sequencer
// and debounce logic into the result register. One tick is taken every
// cycle while results drain; a result held by m_tready low stalls
// s_tready once the input register also holds a tick.
// Reset clears all control state and loads the register defaults.
// cfg_ready is always high; writes to index 3 are ignored.
module typec_cc_attach_detect_debounce (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // delta_ms[7:0], cmp_out[8], pin_high[9], tx_idle[10], rx_pending[11],
    // link_ready[12], fault_active[13], zero[15:14]
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // probe_line[1:0], probe_level[2], measure_done[3], orientation[5:4],
    // is_connected[6], active_line[8:7], attach_event[9], detach_event[10],
    // reselect_event[11], vsafe_request[12], zero[15:13]
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers
    logic [7:0]  attach_debounce_reg;
    logic [7:0]  detach_debounce_reg;
    logic [15:0] check_interval_reg;

    // Detector state
    logic [2:0]  phase_reg,  phase_next;
    logic [2:0]  line1_reg,  line1_next;
    logic [2:0]  line2_reg,  line2_next;
    logic [15:0] timer_reg,  timer_next;
    logic [7:0]  count_reg,  count_next;
    logic        conn_reg,   conn_next;
    logic [1:0]  sel_reg,    sel_next;
    logic [1:0]  orient_reg, orient_next;

    // Pipeline registers
    logic            in_valid_reg;
    tcc_pkg::tick_t  in_data_reg;
    logic            out_valid_reg;
    tcc_pkg::result_t out_data_reg;
    tcc_pkg::result_t result_next;

    logic advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    // Sequencer step outputs, computed from the current state
    logic [2:0] seq_phase, seq_line1, seq_line2;
    logic [1:0] seq_line, seq_orient;
    logic       seq_level, seq_done;

    always_comb
    begin
        seq_line1  = line1_reg;
        seq_line2  = line2_reg;
        seq_orient = orient_reg;
        seq_line   = tcc_pkg::LINE_NONE;
        seq_level  = tcc_pkg::LEVEL_LOW;
        seq_done   = 1'b0;
        case (phase_reg)
            tcc_pkg::PH_CC1_LOW:
            begin
                seq_line1 = '0;
                seq_line2 = '0;
                seq_line  = tcc_pkg::LINE_CC1;
                seq_phase = tcc_pkg::PH_CC1_MID;
            end
            tcc_pkg::PH_CC1_MID:
            begin
                seq_line1[tcc_pkg::FLAG_LOW] = line1_reg[tcc_pkg::FLAG_LOW] |
                                               in_data_reg.cmp_out;
                seq_line  = tcc_pkg::LINE_CC1;
                seq_level = tcc_pkg::LEVEL_MID;
                seq_phase = tcc_pkg::PH_CC1_PIN;
            end
            tcc_pkg::PH_CC1_PIN:
            begin
                seq_line1[tcc_pkg::FLAG_MID]  = line1_reg[tcc_pkg::FLAG_MID] |
                                                in_data_reg.cmp_out;
                seq_line1[tcc_pkg::FLAG_HIGH] = line1_reg[tcc_pkg::FLAG_HIGH] |
                                                in_data_reg.pin_high;
                seq_line  = tcc_pkg::LINE_CC2;
                seq_phase = tcc_pkg::PH_CC2_MID;
            end
            tcc_pkg::PH_CC2_MID:
            begin
                seq_line2[tcc_pkg::FLAG_LOW] = line2_reg[tcc_pkg::FLAG_LOW] |
                                               in_data_reg.cmp_out;
                seq_line  = tcc_pkg::LINE_CC2;
                seq_level = tcc_pkg::LEVEL_MID;
                seq_phase = tcc_pkg::PH_CC2_PIN;
            end
            default:
            begin
                // final phase; out-of-range phases act the same
                seq_line2[tcc_pkg::FLAG_MID]  = line2_reg[tcc_pkg::FLAG_MID] |
                                                in_data_reg.cmp_out;
                seq_line2[tcc_pkg::FLAG_HIGH] = line2_reg[tcc_pkg::FLAG_HIGH] |
                                                in_data_reg.pin_high;
                seq_orient = tcc_pkg::derive(line1_reg, seq_line2);
                seq_done   = 1'b1;
                seq_phase  = tcc_pkg::PH_CC1_LOW;
            end
        endcase
    end

    // Debounce and connection tracking for the tick in the input register
    logic [16:0] timer_sum;
    logic [7:0]  count_bump;
    logic        run;
    logic [2:0]  sel_flags;

    always_comb
    begin
        phase_next  = phase_reg;
        line1_next  = line1_reg;
        line2_next  = line2_reg;
        timer_next  = timer_reg;
        count_next  = count_reg;
        conn_next   = conn_reg;
        sel_next    = sel_reg;
        orient_next = orient_reg;
        result_next = '0;

        timer_sum  = {1'b0, timer_reg} + {9'd0, in_data_reg.delta_ms};
        count_bump = (count_reg < tcc_pkg::COUNT_MAX) ? count_reg + 8'd1 : count_reg;
        sel_flags  = (sel_reg == tcc_pkg::LINE_CC2) ? seq_line2 : seq_line1;

        if (conn_reg) begin
            // advance the interval timer, saturating
            timer_next = timer_sum[16] ? tcc_pkg::TIMER_MAX : timer_sum[15:0];
            run = 1'b1;
            if (!in_data_reg.tx_idle)
                run = 1'b0;
            else if (!in_data_reg.link_ready && in_data_reg.rx_pending &&
                     phase_reg == tcc_pkg::PH_CC1_LOW)
                run = 1'b0;
            else if (phase_reg == tcc_pkg::PH_CC1_LOW && timer_next < check_interval_reg)
                run = 1'b0;
        end else begin
            run = 1'b1;
        end

        if (run) begin
            phase_next           = seq_phase;
            line1_next           = seq_line1;
            line2_next           = seq_line2;
            orient_next          = seq_orient;
            result_next.probe_line  = seq_line;
            result_next.probe_level = seq_level;
        end

        if (run && seq_done) begin
            result_next.measure_done = 1'b1;
            if (conn_reg) begin
                timer_next = '0;
                if (tcc_pkg::looks_rp(sel_flags)) begin
                    count_next = '0;
                    result_next.reselect_event = 1'b1;
                end else if (count_bump >= detach_debounce_reg) begin
                    count_next = '0;
                    conn_next  = 1'b0;
                    sel_next   = tcc_pkg::LINE_NONE;
                    result_next.detach_event = 1'b1;
                end else begin
                    count_next = count_bump;
                    result_next.reselect_event = 1'b1;
                end
            end else begin
                if (seq_orient == tcc_pkg::LINE_NONE) begin
                    count_next = '0;
                end else if (count_bump >= attach_debounce_reg) begin
                    count_next = '0;
                    conn_next  = 1'b1;
                    sel_next   = seq_orient;
                    result_next.attach_event  = 1'b1;
                    result_next.vsafe_request = !in_data_reg.fault_active;
                end else begin
                    count_next = count_bump;
                end
            end
        end

        result_next.orientation  = orient_next;
        result_next.is_connected = conn_next;
        result_next.active_line  = conn_next ? sel_next : tcc_pkg::LINE_NONE;
    end

    // Hold configuration, state and pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            attach_debounce_reg <= tcc_pkg::ATTACH_DEBOUNCE_RST;
            detach_debounce_reg <= tcc_pkg::DETACH_DEBOUNCE_RST;
            check_interval_reg  <= tcc_pkg::CHECK_INTERVAL_MS_RST;
            phase_reg     <= tcc_pkg::PH_CC1_LOW;
            line1_reg     <= '0;
            line2_reg     <= '0;
            timer_reg     <= '0;
            count_reg     <= '0;
            conn_reg      <= 1'b0;
            sel_reg       <= tcc_pkg::LINE_NONE;
            orient_reg    <= tcc_pkg::LINE_NONE;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            // take a register write
            if (cfg_valid) begin
                case (cfg_index)
                    tcc_pkg::REG_ATTACH_DEBOUNCE:   attach_debounce_reg <= cfg_data[7:0];
                    tcc_pkg::REG_DETACH_DEBOUNCE:   detach_debounce_reg <= cfg_data[7:0];
                    tcc_pkg::REG_CHECK_INTERVAL_MS: check_interval_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // input register fill and drain
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            // result register fill and drain
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            // commit one tick
            if (advance) begin
                phase_reg  <= phase_next;
                line1_reg  <= line1_next;
                line2_reg  <= line2_next;
                timer_reg  <= timer_next;
                count_reg  <= count_next;
                conn_reg   <= conn_next;
                sel_reg    <= sel_next;
                orient_reg <= orient_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_data_reg <= s_tdata;
        if (advance)
            out_data_reg <= result_next;
    end

endmodule

[tb/sv/tb_typec_cc_attach_detect_debounce.sv]
// Testbench for the Type-C CC attach/detach detector with debounce.
// Drives poll ticks, tracks detector state in a local predictor and compares
// every result transfer field by field. Depends on tcc_pkg and the top level.
module tb_typec_cc_attach_detect_debounce;

    timeunit 1ns;
    timeprecision 1ps;

    import tcc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Mirror of the detector: settings and control state
    logic [7:0]  att_limit;
    logic [7:0]  det_limit;
    logic [15:0] recheck_limit;
    logic [2:0]  det_phase;
    logic [2:0]  det_fl1;
    logic [2:0]  det_fl2;
    logic [15:0] det_timer;
    logic [7:0]  det_count;
    logic        det_linked;
    logic [1:0]  det_sel;
    logic [1:0]  det_orient;

    // Flag patterns that the stimulus aims for in the current measurement
    logic [2:0]  plan_cc1 = '0;
    logic [2:0]  plan_cc2 = '0;

    result_t     pending_results[$];
    result_t     seen_result;
    result_t     oldest_result;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;

    typec_cc_attach_detect_debounce i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stall the result side at random
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Pull-up seen: above 0.66 V but not driven high
    function automatic logic rp_like(input logic [2:0] f);
        return f[FLAG_MID] & ~f[FLAG_HIGH];
    endfunction

    // Open, Ra-like, or driven high
    function automatic logic other_like(input logic [2:0] f);
        return f[FLAG_HIGH] | (f[FLAG_LOW] & ~f[FLAG_MID]);
    endfunction

    // The two cases exclude each other; both lines pulled up gives none
    function automatic logic [1:0] orient_from(input logic [2:0] a, input logic [2:0] b);
        if (rp_like(a) && other_like(b))
            return LINE_CC1;
        if (rp_like(b) && other_like(a))
            return LINE_CC2;
        return LINE_NONE;
    endfunction

    // Step the probe sequencer; true when a full measurement has finished
    function automatic logic probe_advance(input logic cmp, input logic pin,
                                           output logic [1:0] line, output logic level);
        line  = LINE_NONE;
        level = LEVEL_LOW;
        case (det_phase)
            PH_CC1_LOW:
            begin
                det_fl1   = '0;
                det_fl2   = '0;
                line      = LINE_CC1;
                det_phase = PH_CC1_MID;
            end
            PH_CC1_MID:
            begin
                det_fl1[FLAG_LOW] = det_fl1[FLAG_LOW] | cmp;
                line      = LINE_CC1;
                level     = LEVEL_MID;
                det_phase = PH_CC1_PIN;
            end
            PH_CC1_PIN:
            begin
                det_fl1[FLAG_MID]  = det_fl1[FLAG_MID] | cmp;
                det_fl1[FLAG_HIGH] = det_fl1[FLAG_HIGH] | pin;
                line      = LINE_CC2;
                det_phase = PH_CC2_MID;
            end
            PH_CC2_MID:
            begin
                det_fl2[FLAG_LOW] = det_fl2[FLAG_LOW] | cmp;
                line      = LINE_CC2;
                level     = LEVEL_MID;
                det_phase = PH_CC2_PIN;
            end
            default:
            begin
                // phases past the last one finish the measurement as well
                det_fl2[FLAG_MID]  = det_fl2[FLAG_MID] | cmp;
                det_fl2[FLAG_HIGH] = det_fl2[FLAG_HIGH] | pin;
                det_orient = orient_from(det_fl1, det_fl2);
                det_phase  = PH_CC1_LOW;
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // Saturating debounce count; true once the limit is reached
    function automatic logic count_up(input logic [7:0] limit);
        if (det_count != COUNT_MAX)
            det_count = det_count + 8'd1;
        return det_count >= limit;
    endfunction

    // Apply one poll tick to the mirror and return the result it produces
    function automatic result_t advance_detector(input tick_t t);
        result_t     r;
        logic [16:0] sum;
        logic [2:0]  chk;
        logic [1:0]  line;
        logic        level;
        logic        go;
        logic        done;
        r     = '0;
        line  = LINE_NONE;
        level = LEVEL_LOW;
        done  = 1'b0;
        if (det_linked)
        begin
            // advance the recheck timer on every connected tick, clamp at the top
            sum = {1'b0, det_timer} + {9'd0, t.delta_ms};
            det_timer = sum[16] ? TIMER_MAX : sum[15:0];
            go = t.tx_idle;
            if (det_phase == PH_CC1_LOW && !t.link_ready && t.rx_pending)
                go = 1'b0;
            if (det_phase == PH_CC1_LOW && det_timer < recheck_limit)
                go = 1'b0;
            if (go)
                done = probe_advance(t.cmp_out, t.pin_high, line, level);
            if (done)
            begin
                chk = (det_sel == LINE_CC2) ? det_fl2 : det_fl1;
                det_timer = '0;
                if (rp_like(chk))
                begin
                    det_count = '0;
                    r.reselect_event = 1'b1;
                end
                else if (count_up(det_limit))
                begin
                    det_count  = '0;
                    det_linked = 1'b0;
                    det_sel    = LINE_NONE;
                    r.detach_event = 1'b1;
                end
                else
                begin
                    r.reselect_event = 1'b1;
                end
            end
        end
        else
        begin
            done = probe_advance(t.cmp_out, t.pin_high, line, level);
            if (done)
            begin
                if (det_orient == LINE_NONE)
                    det_count = '0;
                else if (count_up(att_limit))
                begin
                    det_count  = '0;
                    det_linked = 1'b1;
                    det_sel    = det_orient;
                    r.attach_event  = 1'b1;
                    r.vsafe_request = ~t.fault_active;
                end
            end
        end
        r.probe_line   = line;
        r.probe_level  = level;
        r.measure_done = done;
        r.orientation  = det_orient;
        r.is_connected = det_linked;
        r.active_line  = det_linked ? det_sel : LINE_NONE;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch %0d at cycle %0d: %s", mismatch_count, cycle_count, what);
    endtask

    task automatic check_field(input string name, input logic [1:0] seen,
                               input logic [1:0] want);
        if (seen !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, seen, want));
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_result = m_tdata;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result %h with none expected", m_tdata));
            else
            begin
                oldest_result = pending_results.pop_front();
                check_field("probe_line", seen_result.probe_line, oldest_result.probe_line);
                check_field("probe_level", {1'b0, seen_result.probe_level},
                            {1'b0, oldest_result.probe_level});
                check_field("measure_done", {1'b0, seen_result.measure_done},
                            {1'b0, oldest_result.measure_done});
                check_field("orientation", seen_result.orientation,
                            oldest_result.orientation);
                check_field("is_connected", {1'b0, seen_result.is_connected},
                            {1'b0, oldest_result.is_connected});
                check_field("active_line", seen_result.active_line,
                            oldest_result.active_line);
                check_field("attach_event", {1'b0, seen_result.attach_event},
                            {1'b0, oldest_result.attach_event});
                check_field("detach_event", {1'b0, seen_result.detach_event},
                            {1'b0, oldest_result.detach_event});
                check_field("reselect_event", {1'b0, seen_result.reselect_event},
                            {1'b0, oldest_result.reselect_event});
                check_field("vsafe_request", {1'b0, seen_result.vsafe_request},
                            {1'b0, oldest_result.vsafe_request});
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Flags that are not a pull-up: Ra-like or driven high
    function automatic logic [2:0] foreign_flags();
        int         k;
        logic [2:0] f;
        k = $urandom_range(4);
        f = k[2:0] - 3'd1;
        f[FLAG_HIGH] = 1'b1;
        return (k == 0) ? 3'b001 : f;
    endfunction

    // Build a tick; comparator and pin mostly follow a planned line pattern
    function automatic tick_t make_tick(input bit long_gaps);
        tick_t       t;
        logic [31:0] rnd;
        logic [31:0] pick;
        int          roll;
        rnd  = $urandom;
        pick = $urandom;
        roll = $urandom_range(9);
        t = '0;
        // choose the pattern for the next measurement at its first phase
        if (det_phase == PH_CC1_LOW)
        begin
            plan_cc1 = pick[2:0];
            plan_cc2 = pick[5:3];
            if (det_linked)
            begin
                if (roll < 6)
                begin
                    if (det_sel == LINE_CC2)
                        plan_cc2 = {2'b01, pick[6]};
                    else
                        plan_cc1 = {2'b01, pick[6]};
                end
            end
            else if (roll < 4)
            begin
                plan_cc1 = {2'b01, pick[6]};
                plan_cc2 = foreign_flags();
            end
            else if (roll < 8)
            begin
                plan_cc2 = {2'b01, pick[6]};
                plan_cc1 = foreign_flags();
            end
        end
        t.cmp_out      = rnd[8];
        t.pin_high     = rnd[9];
        t.rx_pending   = rnd[10];
        t.fault_active = rnd[11];
        t.tx_idle      = (rnd[18:16] != 3'd0);
        t.link_ready   = (rnd[20:19] != 2'd0);
        // follow the plan most of the time, leave noise otherwise
        if (rnd[24:21] < 4'd14)
        begin
            case (det_phase)
                PH_CC1_LOW: ;
                PH_CC1_MID: t.cmp_out = plan_cc1[FLAG_LOW];
                PH_CC1_PIN:
                begin
                    t.cmp_out  = plan_cc1[FLAG_MID];
                    t.pin_high = plan_cc1[FLAG_HIGH];
                end
                PH_CC2_MID: t.cmp_out = plan_cc2[FLAG_LOW];
                default:
                begin
                    t.cmp_out  = plan_cc2[FLAG_MID];
                    t.pin_high = plan_cc2[FLAG_HIGH];
                end
            endcase
        end
        if (long_gaps)
            t.delta_ms = (rnd[28:25] != 4'd0) ? 8'hFF : rnd[7:0];
        else if (rnd[31:29] < 3'd5)
            t.delta_ms = {3'd0, rnd[4:0]};
        else if (rnd[31:29] < 3'd7)
            t.delta_ms = rnd[7:0];
        else
            t.delta_ms = {8{rnd[5]}};
        return t;
    endfunction

    function automatic tick_t poll(input logic [7:0] ms, input logic cmp, input logic pin,
                                   input logic tx, input logic rx, input logic link,
                                   input logic flt);
        tick_t t;
        t = '0;
        t.delta_ms     = ms;
        t.cmp_out      = cmp;
        t.pin_high     = pin;
        t.tx_idle      = tx;
        t.rx_pending   = rx;
        t.link_ready   = link;
        t.fault_active = flt;
        return t;
    endfunction

    // Send one tick; entered and left just after a falling edge
    task automatic send_tick(input tick_t t);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = t;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(advance_detector(t));
        @(negedge clk);
    endtask

    // Hold off the sender until every expected result has arrived
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // Write all registers, then poke the spare index, which must be ignored
    task automatic write_settings(input logic [7:0] att, input logic [7:0] det,
                                  input logic [15:0] intv);
        logic [1:0]  idx;
        logic [31:0] rnd;
        for (int k = 0; k < 4; k++)
        begin
            idx = k[1:0];
            rnd = $urandom;
            cfg_valid = 1'b1;
            cfg_index = idx;
            case (idx)
                REG_ATTACH_DEBOUNCE:   cfg_data = {8'd0, att};
                REG_DETACH_DEBOUNCE:   cfg_data = {8'd0, det};
                REG_CHECK_INTERVAL_MS: cfg_data = intv;
                default:               cfg_data = rnd[15:0];
            endcase
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx)
                REG_ATTACH_DEBOUNCE:   att_limit     = cfg_data[7:0];
                REG_DETACH_DEBOUNCE:   det_limit     = cfg_data[7:0];
                REG_CHECK_INTERVAL_MS: recheck_limit = cfg_data;
                default: ;
            endcase
            @(negedge clk);
        end
        cfg_valid = 1'b0;
    endtask

    // One block of random traffic under fixed settings and idling
    task automatic run_phase(input int count, input logic [7:0] att, input logic [7:0] det,
                             input logic [15:0] intv, input int src_pct, input int snk_pct,
                             input bit long_gaps, input int drain_every);
        wait_drained();
        write_settings(att, det, intv);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        for (int i = 0; i < count; i++)
        begin
            if (drain_every != 0 && i != 0 && i % drain_every == 0)
                wait_drained();
            send_tick(make_tick(long_gaps));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Both lines pulled up, attach on CC2 with a zero debounce and a fault,
    // connected gating by a busy transmitter and by a pending message,
    // a passing recheck on CC2 and a detach on the first failed one
    task automatic test_directed();
        write_settings(8'd0, 8'd1, 16'd20);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_tick(poll(8'd0,   1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
        send_tick(poll(8'd255, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1));
        send_tick(poll(8'd7,   1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
        send_tick(poll(8'd0,   1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        send_tick(poll(8'd0,   1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
        // CC1 Ra-like, CC2 pulled up
        send_tick(poll(8'd3,   1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
        send_tick(poll(8'd3,   1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
        send_tick(poll(8'd3,   1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
        send_tick(poll(8'd3,   1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
        send_tick(poll(8'd3,   1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1));
        // connected: busy transmitter, then a pending message at phase zero
        send_tick(poll(8'd255, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0));
        send_tick(poll(8'd255, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
        send_tick(poll(8'd0,   1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        send_tick(poll(8'd1,   1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
        send_tick(poll(8'd1,   1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
        send_tick(poll(8'd1,   1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
        send_tick(poll(8'd1,   1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
        // recheck waits one tick short of the interval, then fails on CC2
        send_tick(poll(8'd19,  1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
        send_tick(poll(8'd1,   1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
        send_tick(poll(8'd0,   1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
        send_tick(poll(8'd0,   1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
        send_tick(poll(8'd0,   1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
        send_tick(poll(8'd0,   1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
    endtask

    // Random line patterns under several settings and idling styles
    task automatic test_random_traffic();
        run_phase(50, 8'd3, 8'd3, 16'd100, 0, 0, 1'b0, 25);
        run_phase(50, 8'd1, 8'd1, 16'd0, 59, 0, 1'b0, 0);
        run_phase(50, 8'd2, 8'd4, 16'd300, 0, 59, 1'b0, 0);
        run_phase(50, 8'd5, 8'd2, 16'd30, 24, 24, 1'b0, 0);
    endtask

    // Largest debounce counts, then the longest interval so the timer clamps
    task automatic test_extreme_settings();
        run_phase(30, 8'd255, 8'd255, 16'hFFFF, 24, 24, 1'b0, 0);
        run_phase(320, 8'd1, 8'd1, 16'hFFFF, 0, 0, 1'b1, 0);
    endtask

    initial
    begin
        att_limit     = ATTACH_DEBOUNCE_RST;
        det_limit     = DETACH_DEBOUNCE_RST;
        recheck_limit = CHECK_INTERVAL_MS_RST;
        det_phase  = PH_CC1_LOW;
        det_fl1    = '0;
        det_fl2    = '0;
        det_timer  = '0;
        det_count  = '0;
        det_linked = 1'b0;
        det_sel    = LINE_NONE;
        det_orient = LINE_NONE;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_traffic();
        test_extreme_settings();
        wait_drained();

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[typec_cc_attach_detect_debounce.f]
hw/rtl/tcc_pkg.sv
hw/rtl/typec_cc_attach_detect_debounce.sv
tb/sv/tb_typec_cc_attach_detect_debounce.sv
